[sv/tqnr_pkg.sv]
// Shared types, op codes and constants for the tick-quantized note recorder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tqnr_pkg;

    // Field widths fixed by the beat formats
    localparam int OP_W         = 3;
    localparam int KEY_W        = 2;
    localparam int PITCH_W      = 10;
    localparam int POS_W        = 9;
    localparam int PITCH_FIELDS = 4;

    // Lockout vector: bits 0..3 note keys, then record, play, assign
    localparam int LOCK_W     = 7;
    localparam int LOCK_IDX_W = 3;
    localparam logic [LOCK_IDX_W-1:0] LOCK_RECORD = 3'd4;
    localparam logic [LOCK_IDX_W-1:0] LOCK_PLAY   = 3'd5;
    localparam logic [LOCK_IDX_W-1:0] LOCK_ASSIGN = 3'd6;

    // Default sizes
    localparam int DEF_STORE_DEPTH = 512;
    localparam int DEF_NOTE_KEYS   = 4;

    // Op codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_NOTE   = 3'd1;
    localparam logic [OP_W-1:0] OP_RECORD = 3'd2;
    localparam logic [OP_W-1:0] OP_PLAY   = 3'd3;
    localparam logic [OP_W-1:0] OP_ASSIGN = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [PITCH_W-1:0] pitch_zero;
        logic [PITCH_W-1:0] pitch_one;
        logic [PITCH_W-1:0] pitch_two;
        logic [PITCH_W-1:0] pitch_three;
    } in_beat_t;

    typedef struct packed {
        logic               note_valid;
        logic [PITCH_W-1:0] note_period;
        logic               from_playback;
        logic               is_recording;
        logic               is_playing;
        logic [POS_W-1:0]   position;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // load the accepted input beat
        logic commit;      // apply the beat and load the output register
        logic clear_step;  // zero one store entry and advance the sweep
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;      // output register can take a beat this cycle
        logic clear_needed;  // held beat starts a recording
        logic clear_done;    // sweep is at the last store entry
    } dp_status_t;

endpackage

[sv/tqnr_ctrl.sv]
// Sequencing state machine for the note recorder: clear sweep, accept, execute.
// Depends on tqnr_pkg for the state, command and status types.
`timescale 1ns / 1ps

module tqnr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tqnr_pkg::dp_status_t   status,
    output tqnr_pkg::ctrl_cmd_t    cmd,
    output tqnr_pkg::ctrl_state_t  state
);
    import tqnr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold state; start with a store sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    state_next = status.clear_needed ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready        = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        cmd.clear_step = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                cmd.commit = status.out_free;
            end
            default: begin
                cmd.clear_step = 1'b0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

[sv/tqnr_datapath.sv]
// Datapath of the note recorder: input register, mode and slot registers,
// note store memory with clear sweep, and the output register. Uses tqnr_pkg.
`timescale 1ns / 1ps

module tqnr_datapath #(
    parameter int STORE_DEPTH = tqnr_pkg::DEF_STORE_DEPTH,
    parameter int NOTE_KEYS   = tqnr_pkg::DEF_NOTE_KEYS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tqnr_pkg::in_beat_t    s_data,
    input  tqnr_pkg::ctrl_cmd_t   cmd,
    output tqnr_pkg::dp_status_t  status,
    input  logic                  m_ready,
    output logic                  m_valid,
    output tqnr_pkg::out_beat_t   m_data
);
    import tqnr_pkg::*;

    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int PITCH_SLOTS = (NOTE_KEYS < PITCH_FIELDS) ? NOTE_KEYS : PITCH_FIELDS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(STORE_DEPTH - 1);

    // Architectural state
    in_beat_t            in_reg;
    logic [LOCK_W-1:0]   lock_reg,   lock_next;
    logic [SLOT_W-1:0]   rec_slot_reg,  rec_slot_next;
    logic [SLOT_W-1:0]   play_slot_reg, play_slot_next;
    logic [SLOT_W-1:0]   end_slot_reg,  end_slot_next;
    logic                recording_reg, recording_next;
    logic                playing_reg,   playing_next;
    logic [PITCH_W-1:0]  pitch_reg  [PITCH_SLOTS];
    logic [PITCH_W-1:0]  pitch_next [PITCH_SLOTS];

    // Store and sweep
    logic [PITCH_W-1:0]  store_mem [STORE_DEPTH];
    logic [PITCH_W-1:0]  rd_data_reg;
    logic [SLOT_W-1:0]   clr_cnt_reg;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [PITCH_W-1:0]  wr_data;

    // Output stage
    out_beat_t           out_reg;
    logic                out_valid_reg;
    out_beat_t           result;

    logic [PITCH_W-1:0]  pitch_in [PITCH_FIELDS];
    logic [PITCH_W-1:0]  key_pitch;
    logic                key_ok;
    logic                note_wr;
    logic                clear_needed;

    assign pitch_in[0] = in_reg.pitch_zero;
    assign pitch_in[1] = in_reg.pitch_one;
    assign pitch_in[2] = in_reg.pitch_two;
    assign pitch_in[3] = in_reg.pitch_three;

    assign key_ok = int'(in_reg.key) < NOTE_KEYS;

    // Select the pitch of the pressed key
    always_comb begin
        key_pitch = '0;
        for (int k = 0; k < PITCH_SLOTS; k++) begin
            if (in_reg.key == KEY_W'(k)) begin
                key_pitch = pitch_reg[k];
            end
        end
    end

    // Work out the effect of the held beat
    always_comb begin
        lock_next      = lock_reg;
        rec_slot_next  = rec_slot_reg;
        play_slot_next = play_slot_reg;
        end_slot_next  = end_slot_reg;
        recording_next = recording_reg;
        playing_next   = playing_reg;
        pitch_next     = pitch_reg;
        note_wr        = 1'b0;
        clear_needed   = 1'b0;
        result         = '0;
        case (in_reg.op)
            OP_TICK: begin
                lock_next = '0;
                if (playing_reg) begin
                    result.note_valid    = 1'b1;
                    result.from_playback = 1'b1;
                    result.note_period   = rd_data_reg;
                    play_slot_next       = play_slot_reg + 1'b1;
                    if (play_slot_next >= end_slot_reg) begin
                        playing_next = 1'b0;
                    end
                end
                if (recording_reg) begin
                    rec_slot_next = rec_slot_reg + 1'b1;
                    if (rec_slot_next >= LAST_SLOT) begin
                        recording_next = 1'b0;
                        end_slot_next  = rec_slot_next;
                    end
                end
            end
            OP_NOTE: begin
                if (!playing_reg && key_ok && !lock_reg[{1'b0, in_reg.key}]) begin
                    lock_next[{1'b0, in_reg.key}] = 1'b1;
                    result.note_valid  = 1'b1;
                    result.note_period = key_pitch;
                    note_wr            = recording_reg;
                end
            end
            OP_RECORD: begin
                if (!lock_reg[LOCK_RECORD]) begin
                    lock_next[LOCK_RECORD] = 1'b1;
                    if (recording_reg) begin
                        end_slot_next  = rec_slot_reg;
                        recording_next = 1'b0;
                    end else begin
                        clear_needed   = 1'b1;
                        rec_slot_next  = '0;
                        end_slot_next  = '0;
                        recording_next = 1'b1;
                    end
                end
            end
            OP_PLAY: begin
                if (!lock_reg[LOCK_PLAY]) begin
                    lock_next[LOCK_PLAY] = 1'b1;
                    if (!recording_reg) begin
                        if (playing_reg) begin
                            playing_next = 1'b0;
                        end else begin
                            play_slot_next = '0;
                            playing_next   = 1'b1;
                        end
                    end
                end
            end
            OP_ASSIGN: begin
                if (!lock_reg[LOCK_ASSIGN]) begin
                    lock_next[LOCK_ASSIGN] = 1'b1;
                    for (int k = 0; k < PITCH_SLOTS; k++) begin
                        pitch_next[k] = pitch_in[k];
                    end
                end
            end
            default: begin
                result.note_valid = 1'b0;
            end
        endcase
        result.is_recording = recording_next;
        result.is_playing   = playing_next;
        result.position     = POS_W'(playing_next ? play_slot_next : rec_slot_next);
    end

    // Capture the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
    end

    // Commit mode, slot, lockout and pitch state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg      <= '0;
            rec_slot_reg  <= '0;
            play_slot_reg <= '0;
            end_slot_reg  <= '0;
            recording_reg <= 1'b0;
            playing_reg   <= 1'b0;
            for (int k = 0; k < PITCH_SLOTS; k++) begin
                pitch_reg[k] <= '0;
            end
        end else if (cmd.commit) begin
            lock_reg      <= lock_next;
            rec_slot_reg  <= rec_slot_next;
            play_slot_reg <= play_slot_next;
            end_slot_reg  <= end_slot_next;
            recording_reg <= recording_next;
            playing_reg   <= playing_next;
            pitch_reg     <= pitch_next;
        end
    end

    // Advance the clear sweep; restart it at reset and on every commit
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.commit) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Store port: sweep writes zeros, a recorded note writes its pitch
    assign wr_en   = cmd.clear_step || (cmd.commit && note_wr);
    assign wr_addr = cmd.clear_step ? clr_cnt_reg : rec_slot_reg;
    assign wr_data = cmd.clear_step ? '0 : key_pitch;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[play_slot_reg];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign status.out_free     = !out_valid_reg || m_ready;
    assign status.clear_needed = clear_needed;
    assign status.clear_done   = (clr_cnt_reg == LAST_SLOT);

endmodule

[sv/tick_quantized_note_recorder.sv]
// Tick-quantized note recorder: top level joining controller and datapath.
// A result beat is registered when its input beat executes, which waits while the
// output is full; no new input beat is taken until the last one has executed.
// A record start adds a store clear of all STORE_DEPTH entries, one entry a cycle.
// Reset (aresetn low, synchronous) clears mode, slot, lockout, pitch and output
// valid registers, then s_ready stays low while the note store is swept to zero.
`timescale 1ns / 1ps

module tick_quantized_note_recorder #(
    parameter int STORE_DEPTH = tqnr_pkg::DEF_STORE_DEPTH,
    parameter int NOTE_KEYS   = tqnr_pkg::DEF_NOTE_KEYS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tqnr_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tqnr_pkg::out_beat_t  m_data
);
    import tqnr_pkg::*;

    ctrl_cmd_t   cmd;
    dp_status_t  status;
    ctrl_state_t state;

    tqnr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .state   (state)
    );

    tqnr_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .NOTE_KEYS   (NOTE_KEYS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // No beat is taken while the store is being swept
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_CLEAR) |-> !s_ready)
        else $error("input accepted during store clear");

    // One beat at a time: an accepted beat blocks the next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && state == ST_EXEC))
        else $error("second beat accepted while one is in flight");

    // Every commit presents a result beat on the next cycle
    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("committed beat missing from output");

    // Reset always starts a store sweep
    a_reset_sweeps: assert property (@(posedge aclk)
        !aresetn |=> (state == ST_CLEAR && !m_valid))
        else $error("reset did not start the store clear");

endmodule
